// File: hw/rtl/serpentine_grid_cell_placer_defines.svh
// assertion macros used by the checker file of the serpentine grid cell placer
// depends on nothing; taken in by `include
`ifndef SERPENTINE_GRID_CELL_PLACER_DEFINES_SVH
`define SERPENTINE_GRID_CELL_PLACER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SGCP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SGCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sgcp_pkg.sv
// types, constants and helper functions of the serpentine grid cell placer
// no dependencies; used by every other file of the block but the defines header
package sgcp_pkg;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned SymW    = 2;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned SpanW   = CoordW + 2;
  localparam int unsigned DataW   = 32;
  localparam int unsigned NumRegs = 2;
  localparam int unsigned IdxBit  = 2;
  localparam int unsigned AddrW   = IdxBit + $clog2(NumRegs);

  localparam logic [CoordW-1:0] RowsRst = CoordW'(64);
  localparam logic [CoordW-1:0] ColsRst = CoordW'(64);
  localparam logic [CoordW-1:0] ColEnd  = '1;
  localparam logic [LevelW-1:0] LevelOn = '1;

  // finder squares and alignment square, as offsets from the grid edge
  localparam int FinderSize = 8;
  localparam int AlignFar   = 6;
  localparam int AlignNear  = 2;

  typedef enum logic [SymW-1:0] {
    SymRed   = 2'd0,
    SymBlack = 2'd1,
    SymWhite = 2'd2,
    SymGreen = 2'd3
  } symbol_e;

  typedef enum logic [$clog2(NumRegs)-1:0] {
    RegGridRows = 1'b0,
    RegGridCols = 1'b1
  } reg_idx_e;

  typedef logic signed [SpanW-1:0] span_t;

  typedef struct packed {
    logic [CoordW-1:0] rows;
    logic [CoordW-1:0] cols;
  } grid_cfg_t;

  typedef struct packed {
    logic              hit;
    logic [CoordW-1:0] col;
  } row_hit_t;

  typedef struct packed {
    logic [LevelW-1:0] blue;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] red;
  } levels_t;

  typedef struct packed {
    logic              placed;
    logic [CoordW-1:0] cell_row;
    logic [CoordW-1:0] cell_col;
    logic [SymW-1:0]   colour_code;
    levels_t           levels;
  } result_t;

  function automatic span_t to_span(logic [CoordW-1:0] v);
    return span_t'({{(SpanW-CoordW){1'b0}}, v});
  endfunction

  function automatic levels_t colour_levels(symbol_e s);
    levels_t lv;
    lv = '0;
    case (s)
      SymRed:   lv.red = LevelOn;
      SymBlack: lv = '0;
      SymWhite: lv = '{blue: LevelOn, green: LevelOn, red: LevelOn};
      SymGreen: lv.green = LevelOn;
      default:  lv = '0;
    endcase
    return lv;
  endfunction

  // first free cell of one row, walking from a start column in the row's direction
  function automatic row_hit_t row_search(logic [CoordW-1:0] row, grid_cfg_t cfg, span_t from);
    span_t    r_s;
    span_t    nr_s;
    span_t    nc_s;
    span_t    a_lo;
    span_t    a_hi;
    span_t    b_pos;
    logic     top;
    logic     mid;
    logic     align;
    logic     a_ok;
    logic     b_ok;
    row_hit_t res;
    r_s   = to_span(row);
    nr_s  = to_span(cfg.rows);
    nc_s  = to_span(cfg.cols);
    top   = r_s < span_t'(FinderSize);
    mid   = !top && (r_s < nr_s - span_t'(FinderSize));
    align = !top && !mid && (r_s >= nr_s - span_t'(AlignFar)) &&
            (r_s <= nr_s - span_t'(AlignNear));
    a_lo  = mid ? '0 : span_t'(FinderSize);
    if (top) begin
      a_hi = nc_s - span_t'(FinderSize + 1);
    end else if (align) begin
      a_hi = nc_s - span_t'(AlignFar + 1);
    end else begin
      a_hi = nc_s - span_t'(1);
    end
    b_pos = nc_s - span_t'(1);
    a_ok  = a_lo <= a_hi;
    b_ok  = align && (b_pos >= span_t'(FinderSize));
    res   = '0;
    if (!row[0]) begin
      if (a_ok && (from <= a_hi)) begin
        res.hit = 1'b1;
        res.col = (from > a_lo) ? from[CoordW-1:0] : a_lo[CoordW-1:0];
      end else if (b_ok && (from <= b_pos)) begin
        res.hit = 1'b1;
        res.col = b_pos[CoordW-1:0];
      end
    end else begin
      if (b_ok && (from >= b_pos)) begin
        res.hit = 1'b1;
        res.col = b_pos[CoordW-1:0];
      end else if (a_ok && (from >= a_lo)) begin
        res.hit = 1'b1;
        res.col = (from < a_hi) ? from[CoordW-1:0] : a_hi[CoordW-1:0];
      end
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/sgcp_if.sv
// request and result channel interfaces of the serpentine grid cell placer
// depends on sgcp_pkg
interface sgcp_req_if;
  import sgcp_pkg::*;

  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            start_frame;

  modport source (output valid, symbol, start_frame, input ready);
  modport sink (input valid, symbol, start_frame, output ready);
endinterface

interface sgcp_res_if;
  import sgcp_pkg::*;

  logic              valid;
  logic              ready;
  logic              placed;
  logic [CoordW-1:0] cell_row;
  logic [CoordW-1:0] cell_col;
  logic [SymW-1:0]   colour_code;
  logic [LevelW-1:0] blue_level;
  logic [LevelW-1:0] green_level;
  logic [LevelW-1:0] red_level;

  modport source (
    output valid, placed, cell_row, cell_col, colour_code, blue_level, green_level, red_level,
    input  ready
  );
  modport sink (
    input  valid, placed, cell_row, cell_col, colour_code, blue_level, green_level, red_level,
    output ready
  );
endinterface

// File: hw/rtl/sgcp_cfg_regs.sv
// apb register file holding the grid size
// depends on sgcp_pkg
module sgcp_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sgcp_pkg::AddrW-1:0] paddr,
  input  logic [sgcp_pkg::DataW-1:0] pwdata,
  output logic [sgcp_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output sgcp_pkg::grid_cfg_t        cfg_o
);
  import sgcp_pkg::*;

  logic [CoordW-1:0] rows_q;
  logic [CoordW-1:0] rows_d;
  logic [CoordW-1:0] cols_q;
  logic [CoordW-1:0] cols_d;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:IdxBit]);

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    prdata = '0;
    case (idx)
      RegGridRows: begin
        prdata[CoordW-1:0] = rows_q;
        if (wr_en) begin
          rows_d = pwdata[CoordW-1:0];
        end
      end
      RegGridCols: begin
        prdata[CoordW-1:0] = cols_q;
        if (wr_en) begin
          cols_d = pwdata[CoordW-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowsRst;
      cols_q <= ColsRst;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  assign cfg_o = '{rows: rows_q, cols: cols_q};

endmodule

// File: hw/rtl/sgcp_cursor.sv
// scan cursor and combinational search for the next free cell
// depends on sgcp_pkg
module sgcp_cursor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sgcp_pkg::grid_cfg_t       cfg_i,
  input  logic                      step_i,
  input  logic [sgcp_pkg::SymW-1:0] symbol_i,
  input  logic                      start_frame_i,
  output sgcp_pkg::result_t         result_o
);
  import sgcp_pkg::*;

  logic [CoordW-1:0] scan_row_q;
  logic [CoordW-1:0] scan_row_d;
  logic [CoordW-1:0] scan_col_q;
  logic [CoordW-1:0] scan_col_d;
  logic [CoordW-1:0] row0;
  logic [CoordW-1:0] col0;
  logic [CoordW-1:0] row1;
  logic [CoordW-1:0] found_row;
  logic [CoordW-1:0] found_col;
  logic [CoordW-1:0] stray_col;
  logic              odd0;
  logic              past_left;
  logic              active;
  logic              in_row;
  logic              row_done;
  logic              on_track;
  logic              row1_ok;
  logic              row8_ok;
  logic              found;
  span_t             rows_s;
  span_t             cols_s;
  span_t             row0_s;
  span_t             col0_s;
  span_t             entry1;
  row_hit_t          hit0;
  row_hit_t          hit1;
  row_hit_t          hit8;

  always_comb begin
    row0      = start_frame_i ? '0 : scan_row_q;
    col0      = start_frame_i ? '0 : scan_col_q;
    odd0      = row0[0];
    past_left = odd0 && (col0 == ColEnd);
    rows_s    = to_span(cfg_i.rows);
    cols_s    = to_span(cfg_i.cols);
    row0_s    = to_span(row0);
    col0_s    = past_left ? span_t'(-1) : to_span(col0);
    active    = row0_s < rows_s;
    in_row    = (col0_s >= span_t'(0)) && (col0_s < cols_s);
    row_done  = past_left || (!odd0 && (col0_s == cols_s));
    on_track  = in_row || row_done;

    hit0    = row_search(row0, cfg_i, col0_s);
    row1    = row0 + CoordW'(1);
    entry1  = row1[0] ? cols_s - span_t'(1) : '0;
    hit1    = row_search(row1, cfg_i, entry1);
    row1_ok = to_span(row1) < rows_s;
    // top rows all reserved: the next candidate is the first row under the finders
    row8_ok = (row0_s < span_t'(FinderSize - 1)) && (span_t'(FinderSize) < rows_s);
    hit8    = row_search(CoordW'(FinderSize), cfg_i, '0);

    found     = 1'b0;
    found_row = row0;
    found_col = hit0.col;
    if (active) begin
      if (in_row && hit0.hit) begin
        found = 1'b1;
      end else if (on_track && row1_ok && hit1.hit) begin
        found     = 1'b1;
        found_row = row1;
        found_col = hit1.col;
      end else if (on_track && row8_ok && hit8.hit) begin
        found     = 1'b1;
        found_row = CoordW'(FinderSize);
        found_col = hit8.col;
      end
    end

    // cursor left off the grid: it moves by one column when an odd number of rows remain, else it stays
    if (cfg_i.rows[0] ^ odd0) begin
      stray_col = odd0 ? col0 + CoordW'(1) : col0 - CoordW'(1);
    end else begin
      stray_col = col0;
    end

    result_o   = '0;
    scan_row_d = row0;
    scan_col_d = col0;
    if (found) begin
      result_o.placed      = 1'b1;
      result_o.cell_row    = found_row;
      result_o.cell_col    = found_col;
      result_o.colour_code = symbol_i;
      result_o.levels      = colour_levels(symbol_e'(symbol_i));
      scan_row_d           = found_row;
      scan_col_d           = found_row[0] ? found_col - CoordW'(1) : found_col + CoordW'(1);
    end else if (active) begin
      scan_row_d = cfg_i.rows;
      if (on_track) begin
        scan_col_d = cfg_i.rows[0] ? cfg_i.cols - CoordW'(1) : '0;
      end else begin
        scan_col_d = stray_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= '0;
      scan_col_q <= '0;
    end else if (step_i) begin
      scan_row_q <= scan_row_d;
      scan_col_q <= scan_col_d;
    end
  end

endmodule

// File: hw/rtl/serpentine_grid_cell_placer.sv
// top level of the serpentine grid cell placer: request register, cursor, result register
// depends on sgcp_pkg, sgcp_if, sgcp_cfg_regs and sgcp_cursor
//
// Takes one request per clock cycle while the result side is ready and returns one result for
// each, in order. A request lands in an input register; the next free cell of the serpentine
// scan is then found combinationally by comparators on the row bands of the grid (finder rows,
// plain rows, alignment rows) and lands in the result register, while the cursor moves on for
// the following request. Stalls on the result side hold one result and one request before
// ready drops. A full grid gives placed low with all other fields zero. Grid rows and columns
// are written over apb at byte addresses 0 and 4; the user writes them only while no request
// is in flight, which the block does not enforce. Both reset to 64. No memory, no clearing pass.
module serpentine_grid_cell_placer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sgcp_req_if.sink                   req_i,
  sgcp_res_if.source                 res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sgcp_pkg::AddrW-1:0] paddr,
  input  logic [sgcp_pkg::DataW-1:0] pwdata,
  output logic [sgcp_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import sgcp_pkg::*;

  grid_cfg_t       cfg;
  result_t         result;
  result_t         out_res_q;
  logic            out_valid_q;
  logic            out_valid_d;
  logic            in_valid_q;
  logic            in_valid_d;
  logic [SymW-1:0] in_sym_q;
  logic            in_start_q;
  logic            out_free;
  logic            advance;
  logic            take;

  sgcp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sgcp_cursor u_cursor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .step_i        (advance),
    .symbol_i      (in_sym_q),
    .start_frame_i (in_start_q),
    .result_o      (result)
  );

  assign out_free    = !out_valid_q || res_o.ready;
  assign advance     = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || advance;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_sym_q   <= req_i.symbol;
      in_start_q <= req_i.start_frame;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= result;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.placed      = out_res_q.placed;
  assign res_o.cell_row    = out_res_q.cell_row;
  assign res_o.cell_col    = out_res_q.cell_col;
  assign res_o.colour_code = out_res_q.colour_code;
  assign res_o.blue_level  = out_res_q.levels.blue;
  assign res_o.green_level = out_res_q.levels.green;
  assign res_o.red_level   = out_res_q.levels.red;

endmodule

// File: hw/rtl/sgcp_checker.sv
// port-level checker of the serpentine grid cell placer and its bind
// depends on sgcp_pkg and serpentine_grid_cell_placer_defines.svh
`include "serpentine_grid_cell_placer_defines.svh"

module sgcp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic                        placed_i,
  input logic [sgcp_pkg::CoordW-1:0] cell_row_i,
  input logic [sgcp_pkg::CoordW-1:0] cell_col_i,
  input logic [sgcp_pkg::SymW-1:0]   colour_code_i,
  input logic [sgcp_pkg::LevelW-1:0] blue_level_i,
  input logic [sgcp_pkg::LevelW-1:0] green_level_i,
  input logic [sgcp_pkg::LevelW-1:0] red_level_i
);
  import sgcp_pkg::*;

  localparam int unsigned PayloadW = 1 + 2 * CoordW + SymW + 3 * LevelW;

  levels_t             seen_levels;
  levels_t             want_levels;
  logic [PayloadW-1:0] payload;
  logic                stalled;
  logic                full_res;
  logic                placed_res;
  logic                all_zero;

  assign seen_levels = '{blue: blue_level_i, green: green_level_i, red: red_level_i};
  assign want_levels = colour_levels(symbol_e'(colour_code_i));
  assign payload     = {placed_i, cell_row_i, cell_col_i, colour_code_i, seen_levels};
  assign stalled     = res_valid_i && !res_ready_i;
  assign full_res    = res_valid_i && !placed_i;
  assign placed_res  = res_valid_i && placed_i;
  assign all_zero    = (cell_row_i == '0) && (cell_col_i == '0) && (colour_code_i == '0) &&
                       (seen_levels == '0);

  `SGCP_ASSERT_SAME(a_full_grid_zero, clk_i, rst_ni, full_res, all_zero, "full grid result not zero")
  `SGCP_ASSERT_SAME(a_levels_match, clk_i, rst_ni, placed_res, seen_levels == want_levels, "colour levels do not match colour code")
  `SGCP_ASSERT_NEXT(a_valid_held, clk_i, rst_ni, stalled, res_valid_i, "result dropped while stalled")
  `SGCP_ASSERT_NEXT(a_payload_held, clk_i, rst_ni, stalled, $stable(payload), "result changed while stalled")

endmodule

bind serpentine_grid_cell_placer sgcp_checker u_sgcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .placed_i      (res_o.placed),
  .cell_row_i    (res_o.cell_row),
  .cell_col_i    (res_o.cell_col),
  .colour_code_i (res_o.colour_code),
  .blue_level_i  (res_o.blue_level),
  .green_level_i (res_o.green_level),
  .red_level_i   (res_o.red_level)
);
